// ===== rtl/trps_pkg.sv =====
// ----------------------------------------------------------------------------
// trps_pkg: shared types and helpers for the torus route port selector
// node and register widths, role and direction codes, direction reversal and one division step
// ----------------------------------------------------------------------------
package trps_pkg;

  localparam int unsigned NodeW = 6;
  localparam int unsigned SizeW = 7;
  localparam int unsigned CntW  = 2 * SizeW;
  localparam int unsigned IdxW  = 1;

  localparam logic [IdxW-1:0] CFG_GRID_ROWS = 1'b0;
  localparam logic [IdxW-1:0] CFG_GRID_COLS = 1'b1;

  typedef enum logic [1:0] {
    ROLE_NONE = 2'd0,
    ROLE_SRC  = 2'd1,
    ROLE_FWD  = 2'd2,
    ROLE_DST  = 2'd3
  } role_e;

  typedef enum logic [2:0] {
    DIR_NONE  = 3'd0,
    DIR_UP    = 3'd1,
    DIR_LEFT  = 3'd2,
    DIR_DOWN  = 3'd3,
    DIR_RIGHT = 3'd4
  } dir_e;

  typedef struct packed {
    logic on_path;
    logic inc;
  } ring_t;

  function automatic dir_e opposite(dir_e dir);
    dir_e res;
    case (dir)
      DIR_UP:    res = DIR_DOWN;
      DIR_DOWN:  res = DIR_UP;
      DIR_LEFT:  res = DIR_RIGHT;
      DIR_RIGHT: res = DIR_LEFT;
      default:   res = DIR_NONE;
    endcase
    return res;
  endfunction

  // restoring division step: returns {quotient bit, new remainder}
  function automatic logic [SizeW:0] div_step(logic [SizeW-1:0] rem, logic nb,
                                               logic [SizeW-1:0] d);
    logic [SizeW:0] t;
    logic [SizeW:0] res;
    t = {rem, nb};
    if (t >= {1'b0, d}) begin
      res = {1'b1, SizeW'(t - {1'b0, d})};
    end else begin
      res = {1'b0, t[SizeW-1:0]};
    end
    return res;
  endfunction

endpackage

// ===== rtl/trps_req_if.sv =====
// ----------------------------------------------------------------------------
// trps_req_if: request channel
// valid/ready handshake carrying source, destination and queried node
// ----------------------------------------------------------------------------
interface trps_req_if
  import trps_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [NodeW-1:0] source_node;
  logic [NodeW-1:0] dest_node;
  logic [NodeW-1:0] here_node;

  modport source (output valid, output source_node, output dest_node,
                  output here_node, input ready);
  modport sink   (input valid, input source_node, input dest_node,
                  input here_node, output ready);
endinterface

// ===== rtl/trps_rsp_if.sv =====
// ----------------------------------------------------------------------------
// trps_rsp_if: response channel
// valid/ready handshake carrying role and receive/send directions
// ----------------------------------------------------------------------------
interface trps_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] role;
  logic [2:0] recv_dir;
  logic [2:0] send_dir;

  modport source (output valid, output role, output recv_dir, output send_dir,
                  input ready);
  modport sink   (input valid, input role, input recv_dir, input send_dir,
                  output ready);
endinterface

// ===== rtl/trps_ring.sv =====
// ----------------------------------------------------------------------------
// trps_ring: one ring dimension of the route
// picks the short way round and tests whether a position lies on the path
// ----------------------------------------------------------------------------
module trps_ring
  import trps_pkg::*;
(
  input  logic [NodeW-1:0] pos_s_i,
  input  logic [NodeW-1:0] pos_d_i,
  input  logic [NodeW-1:0] pos_x_i,
  input  logic [SizeW-1:0] size_i,
  output ring_t            ring_o
);

  logic [NodeW-1:0] lo;
  logic [NodeW-1:0] hi;
  logic [NodeW-1:0] span;
  logic [SizeW-1:0] mid;
  logic             wrap;

  always_comb begin
    lo   = (pos_s_i < pos_d_i) ? pos_s_i : pos_d_i;
    hi   = (pos_s_i < pos_d_i) ? pos_d_i : pos_s_i;
    span = hi - lo;
    mid  = (size_i - SizeW'(1)) >> 1;
    wrap = ({1'b0, span} > mid) && (span != NodeW'(1));
    ring_o.inc = (pos_d_i > pos_s_i) != wrap;
    if (wrap) begin
      ring_o.on_path = (pos_x_i <= lo) || (pos_x_i >= hi);
    end else begin
      ring_o.on_path = (pos_x_i >= lo) && (pos_x_i <= hi);
    end
  end

endmodule

// ===== rtl/torus_route_port_select.sv =====
// ----------------------------------------------------------------------------
// torus_route_port_select: dimension-order route role and ports on a torus
// throughput one word per cycle while rsp.ready is high: two stages of
// node/column division, one of ring decisions, one output register; each
// stage stalls only when full
// reset clears the pipeline valid bits and sets the grid to 1 x 1
// ----------------------------------------------------------------------------
module torus_route_port_select
  import trps_pkg::*;
#(
  parameter int unsigned MAX_NODES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IdxW-1:0]   cfg_idx_i,
  input  logic [SizeW-1:0]  cfg_data_i,
  trps_req_if.sink          req,
  trps_rsp_if.source        rsp
);

  localparam int unsigned NodeNum = 3;
  localparam int unsigned NSrc    = 0;
  localparam int unsigned NDst    = 1;
  localparam int unsigned NHere   = 2;
  localparam int unsigned HalfW   = NodeW / 2;
  localparam logic [CntW-1:0] NodeCap = CntW'(MAX_NODES);

  typedef struct packed {
    logic                                bad;
    logic                                is_dst;
    logic                                is_src;
    logic [NodeNum-1:0][SizeW-1:0]       rem;
    logic [NodeNum-1:0][NodeW-1:0]       num;
    logic [NodeNum-1:0][HalfW-1:0]       qhi;
  } s1_t;

  typedef struct packed {
    logic                                bad;
    logic                                is_dst;
    logic                                is_src;
    logic [NodeNum-1:0][NodeW-1:0]       rowp;
    logic [NodeNum-1:0][NodeW-1:0]       colp;
  } s2_t;

  typedef struct packed {
    logic  bad;
    logic  is_dst;
    logic  is_src;
    logic  same_col;
    logic  row_differs;
    logic  here_off_row;
    logic  here_on_col;
    logic  on_vert;
    logic  on_horz;
    ring_t row_r;
    ring_t col_r;
  } s3_t;

  typedef struct packed {
    role_e role;
    dir_e  recv_dir;
    dir_e  send_dir;
  } out_t;

  logic [SizeW-1:0] grid_rows_q, grid_cols_q;
  logic [SizeW-1:0] rows_eff, cols_eff;
  logic [CntW-1:0]  prod, count;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  out_t out_d, out_q;

  logic [NodeNum-1:0][NodeW-1:0] nodes;
  logic [SizeW-1:0]              rem1, rem2;
  logic [SizeW:0]                st1, st2;
  logic [HalfW-1:0]              qlo;
  ring_t                         row_r, col_r;
  dir_e                          row_move, col_move;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= SizeW'(1);
      grid_cols_q <= SizeW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRID_ROWS: grid_rows_q <= cfg_data_i;
        CFG_GRID_COLS: grid_cols_q <= cfg_data_i;
      endcase
    end
  end

  assign rows_eff = (grid_rows_q == '0) ? SizeW'(1) : grid_rows_q;
  assign cols_eff = (grid_cols_q == '0) ? SizeW'(1) : grid_cols_q;
  assign prod     = rows_eff * cols_eff;
  assign count    = (prod > NodeCap) ? NodeCap : prod;

  // stall chain
  assign rdy4      = !v4_q || rsp.ready;
  assign rdy3      = !v3_q || rdy4;
  assign rdy2      = !v2_q || rdy3;
  assign rdy1      = !v1_q || rdy2;
  assign req.ready = rdy1;

  // stage 1: range and source/destination checks, upper quotient bits
  assign nodes[NSrc]  = req.source_node;
  assign nodes[NDst]  = req.dest_node;
  assign nodes[NHere] = req.here_node;

  always_comb begin
    s1_d        = '0;
    rem1        = '0;
    st1         = '0;
    s1_d.bad    = (req.source_node == req.dest_node)
               || (CntW'(req.source_node) >= count)
               || (CntW'(req.dest_node) >= count)
               || (CntW'(req.here_node) >= count);
    s1_d.is_dst = req.here_node == req.dest_node;
    s1_d.is_src = req.here_node == req.source_node;
    for (int n = 0; n < NodeNum; n++) begin
      rem1 = '0;
      for (int b = NodeW - 1; b >= HalfW; b--) begin
        st1                   = div_step(rem1, nodes[n][b], cols_eff);
        s1_d.qhi[n][b-HalfW]  = st1[SizeW];
        rem1                  = st1[SizeW-1:0];
      end
      s1_d.rem[n] = rem1;
      s1_d.num[n] = nodes[n];
    end
  end

  // stage 2: lower quotient bits, remainder gives the column
  always_comb begin
    s2_d        = '0;
    rem2        = '0;
    st2         = '0;
    qlo         = '0;
    s2_d.bad    = s1_q.bad;
    s2_d.is_dst = s1_q.is_dst;
    s2_d.is_src = s1_q.is_src;
    for (int n = 0; n < NodeNum; n++) begin
      rem2 = s1_q.rem[n];
      for (int b = HalfW - 1; b >= 0; b--) begin
        st2    = div_step(rem2, s1_q.num[n][b], cols_eff);
        qlo[b] = st2[SizeW];
        rem2   = st2[SizeW-1:0];
      end
      s2_d.rowp[n] = {s1_q.qhi[n], qlo};
      s2_d.colp[n] = rem2[NodeW-1:0];
    end
  end

  // stage 3: ring decisions
  trps_ring u_row (
    .pos_s_i (s2_q.rowp[NSrc]),
    .pos_d_i (s2_q.rowp[NDst]),
    .pos_x_i (s2_q.rowp[NHere]),
    .size_i  (rows_eff),
    .ring_o  (row_r)
  );

  trps_ring u_col (
    .pos_s_i (s2_q.colp[NSrc]),
    .pos_d_i (s2_q.colp[NDst]),
    .pos_x_i (s2_q.colp[NHere]),
    .size_i  (cols_eff),
    .ring_o  (col_r)
  );

  always_comb begin
    s3_d.bad          = s2_q.bad;
    s3_d.is_dst       = s2_q.is_dst;
    s3_d.is_src       = s2_q.is_src;
    s3_d.same_col     = s2_q.colp[NSrc] == s2_q.colp[NDst];
    s3_d.row_differs  = s2_q.rowp[NSrc] != s2_q.rowp[NDst];
    s3_d.here_off_row = s2_q.rowp[NHere] != s2_q.rowp[NDst];
    s3_d.here_on_col  = s2_q.colp[NHere] == s2_q.colp[NSrc];
    s3_d.on_vert      = s3_d.here_on_col && row_r.on_path;
    s3_d.on_horz      = !s3_d.here_off_row && col_r.on_path;
    s3_d.row_r        = row_r;
    s3_d.col_r        = col_r;
  end

  // stage 4: role and port selection
  assign row_move = s3_q.row_r.inc ? DIR_DOWN : DIR_UP;
  assign col_move = s3_q.col_r.inc ? DIR_RIGHT : DIR_LEFT;

  always_comb begin
    out_d.role     = ROLE_NONE;
    out_d.recv_dir = DIR_NONE;
    out_d.send_dir = DIR_NONE;
    priority if (s3_q.bad || (!s3_q.on_vert && !s3_q.on_horz)) begin
      out_d.role = ROLE_NONE;
    end else if (s3_q.is_dst) begin
      out_d.role     = ROLE_DST;
      out_d.recv_dir = s3_q.same_col ? opposite(row_move) : opposite(col_move);
    end else if (s3_q.is_src) begin
      out_d.role     = ROLE_SRC;
      out_d.send_dir = s3_q.row_differs ? row_move : col_move;
    end else if (s3_q.here_off_row) begin
      out_d.role     = ROLE_FWD;
      out_d.recv_dir = opposite(row_move);
      out_d.send_dir = row_move;
    end else begin
      out_d.role     = ROLE_FWD;
      out_d.recv_dir = s3_q.here_on_col ? opposite(row_move) : opposite(col_move);
      out_d.send_dir = col_move;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= req.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (rdy1 && req.valid) s1_q <= s1_d;
    if (rdy2 && v1_q)      s2_q <= s2_d;
    if (rdy3 && v2_q)      s3_q <= s3_d;
    if (rdy4 && v3_q)      out_q <= out_d;
  end

  assign rsp.valid    = v4_q;
  assign rsp.role     = out_q.role;
  assign rsp.recv_dir = out_q.recv_dir;
  assign rsp.send_dir = out_q.send_dir;

  // checks
  a_none_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && (rsp.role == ROLE_NONE) |->
      (rsp.recv_dir == DIR_NONE) && (rsp.send_dir == DIR_NONE))
    else $error("inactive word carries a direction");

  a_src_ports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && (rsp.role == ROLE_SRC) |->
      (rsp.recv_dir == DIR_NONE) && (rsp.send_dir != DIR_NONE))
    else $error("source word has wrong ports");

  a_dst_ports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && (rsp.role == ROLE_DST) |->
      (rsp.send_dir == DIR_NONE) && (rsp.recv_dir != DIR_NONE))
    else $error("destination word has wrong ports");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid && req.ready |=> v1_q)
    else $error("accepted word lost at first stage");

endmodule
